// ===== hw/rtl/salc_pkg.sv =====
// salc_pkg: shared constants, types and helpers of the LRU cache simulator.
// No dependencies; every other file refers to it by scoped names.
package salc_pkg;

  // Cache geometry
  localparam int MAX_SETS   = 256;
  localparam int MAX_WAYS   = 8;
  localparam int SET_W      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W     = $clog2(MAX_WAYS + 1);

  // Field widths
  localparam int ADDR_W     = 64;
  localparam int TAG_W      = 64;
  localparam int STAMP_W    = 64;
  localparam int TOTAL_W    = 32;
  localparam int SHIFT_W    = 7;
  localparam int SIB_W      = 4;
  localparam int WAYS_CFG_W = 4;
  localparam int BOB_W      = 6;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_SET_INDEX_BITS    = 2'd0;
  localparam logic [1:0] REG_WAYS_IN_USE       = 2'd1;
  localparam logic [1:0] REG_BLOCK_OFFSET_BITS = 2'd2;

  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [TOTAL_W-1:0] total_t;

  // Access kinds; an ignored access changes nothing and returns no item
  typedef enum logic [1:0] {
    REQ_LOAD,
    REQ_STORE,
    REQ_MODIFY,
    REQ_IGNORE
  } req_type_t;

  // One memory row holds a whole set
  typedef struct packed {
    logic [MAX_WAYS-1:0]   valid;
    tag_t [MAX_WAYS-1:0]   tag;
    stamp_t [MAX_WAYS-1:0] stamp;
  } row_t;

  // Replacement candidates handed to the LRU picker
  typedef struct packed {
    logic [MAX_WAYS-1:0]   en;
    stamp_t [MAX_WAYS-1:0] stamp;
  } cand_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_PICK,
    ST_DONE
  } state_t;

  // Saturating increment of a running total
  function automatic total_t sat_inc(total_t v);
    return (v == '1) ? v : v + total_t'(1);
  endfunction

endpackage

// ===== hw/rtl/salc_if.sv =====
// salc_in_if / salc_out_if: valid-ready channels of the LRU cache simulator.
// Depends on salc_pkg for field widths.
interface salc_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [salc_pkg::ADDR_W-1:0] address;

  modport source (output valid, req_type, address, input ready);
  modport sink   (input valid, req_type, address, output ready);
endinterface

interface salc_out_if;
  logic                 valid;
  logic                 ready;
  logic                 was_hit;
  logic                 was_miss;
  logic                 was_eviction;
  logic                 modify_extra_hit;
  salc_pkg::total_t     hit_total;
  salc_pkg::total_t     miss_total;
  salc_pkg::total_t     eviction_total;

  modport source (output valid, was_hit, was_miss, was_eviction, modify_extra_hit,
                  hit_total, miss_total, eviction_total, input ready);
  modport sink   (input valid, was_hit, was_miss, was_eviction, modify_extra_hit,
                  hit_total, miss_total, eviction_total, output ready);
endinterface

// ===== hw/rtl/set_assoc_lru_cache_sim.sv =====
// Set-associative cache simulator with LRU replacement and saturating
// hit, miss and eviction totals. Each set is one row of a synchronous memory
// holding valid bits, tags and stamps of all ways; an access reads the row,
// compares tags, picks the LRU way and writes the row back. The row is read
// at the accepting edge, then tag compare (LOOK), LRU pick (PICK) and
// write-back (DONE) follow in that order. The result shows once DONE has
// written the row back, and the next access can be taken in the cycle in which
// it shows. The block handles one access at a time, set by the read-modify-write of the single row memory.
// A result that is not taken holds the write-back of the following access,
// and the input stalls until the result leaves. An access of type 3 is taken
// in the idle state and produces no item. After reset the block clears the
// valid bits of all 256 sets, one after another, before it takes the first
// access; configuration writes are taken throughout. The result waits in an
// output register, so the next access can start while it is not yet taken.
module set_assoc_lru_cache_sim (
  input  logic                               clk,
  input  logic                               rst_n,
  salc_in_if.sink                            in_ch,
  salc_out_if.source                         out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [salc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [salc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [salc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  // Configuration registers
  logic [salc_pkg::SIB_W-1:0]      sib_r;
  logic [salc_pkg::WAYS_CFG_W-1:0] ways_cfg_r;
  logic [salc_pkg::BOB_W-1:0]      bob_r;
  logic                            cfg_wr;
  logic [1:0]                      cfg_idx;

  // Control state
  salc_pkg::state_t                state_r, state_nxt;
  logic [salc_pkg::SET_W-1:0]      clr_cnt_r;
  logic                            out_valid_r;

  // Access in flight
  logic [salc_pkg::SET_W-1:0]      set_r;
  salc_pkg::tag_t                  tag_r;
  salc_pkg::req_type_t             kind_r;
  logic [salc_pkg::MAX_WAYS-1:0]   en_r;
  logic                            hit_r, empty_r;
  logic [salc_pkg::WAY_W-1:0]      hit_way_r, empty_way_r, victim_r;

  // Totals and access clock
  salc_pkg::total_t                hits_r, misses_r, evicts_r;
  salc_pkg::total_t                hits_nxt, misses_nxt, evicts_nxt, hits_mod;
  salc_pkg::stamp_t                clock_r;

  // Result flags
  logic                            o_hit_r, o_miss_r, o_evict_r, o_mod_r;

  // Set memory
  salc_pkg::row_t                  line_mem [salc_pkg::MAX_SETS];
  salc_pkg::row_t                  rd_row_r;
  salc_pkg::row_t                  wr_row;
  logic                            mem_we, mem_re;
  logic [salc_pkg::SET_W-1:0]      mem_waddr;

  // Accept-side decode
  logic                            in_acc;
  logic [salc_pkg::SHIFT_W-1:0]    shift_total;
  logic [salc_pkg::ADDR_W-1:0]     set_shift, set_mask, set_raw;
  logic [salc_pkg::SET_W-1:0]      acc_set;
  salc_pkg::tag_t                  acc_tag;
  logic [salc_pkg::WCNT_W-1:0]     ways_eff;
  logic [salc_pkg::MAX_WAYS-1:0]   acc_en;

  // Lookup results
  logic                            hit_c, empty_c;
  logic [salc_pkg::WAY_W-1:0]      hit_way_c, empty_way_c, victim_c, way_sel;
  salc_pkg::cand_t                 cand;
  logic                            done_fire, evict_c;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sib_r      <= '0;
      ways_cfg_r <= salc_pkg::WAYS_CFG_W'(1);
      bob_r      <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        salc_pkg::REG_SET_INDEX_BITS:    sib_r      <= cfg_pwdata[salc_pkg::SIB_W-1:0];
        salc_pkg::REG_WAYS_IN_USE:       ways_cfg_r <= cfg_pwdata[salc_pkg::WAYS_CFG_W-1:0];
        salc_pkg::REG_BLOCK_OFFSET_BITS: bob_r      <= cfg_pwdata[salc_pkg::BOB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      salc_pkg::REG_SET_INDEX_BITS:    cfg_prdata = salc_pkg::CFG_DATA_W'(sib_r);
      salc_pkg::REG_WAYS_IN_USE:       cfg_prdata = salc_pkg::CFG_DATA_W'(ways_cfg_r);
      salc_pkg::REG_BLOCK_OFFSET_BITS: cfg_prdata = salc_pkg::CFG_DATA_W'(bob_r);
      default:                         cfg_prdata = '0;
    endcase
  end

  // ---------------- address split and way range ----------------
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign shift_total = salc_pkg::SHIFT_W'(bob_r) + salc_pkg::SHIFT_W'(sib_r);
  assign set_shift   = in_ch.address >> bob_r;
  assign set_mask    = ~({salc_pkg::ADDR_W{1'b1}} << sib_r);
  assign set_raw     = set_shift & set_mask;
  assign acc_set     = set_raw[salc_pkg::SET_W-1:0];
  assign acc_tag     = (shift_total >= salc_pkg::SHIFT_W'(salc_pkg::ADDR_W)) ? '0
                     : (in_ch.address >> shift_total);

  always_comb begin
    if (ways_cfg_r == '0) begin
      ways_eff = salc_pkg::WCNT_W'(1);
    end else if (int'(ways_cfg_r) > salc_pkg::MAX_WAYS) begin
      ways_eff = salc_pkg::WCNT_W'(salc_pkg::MAX_WAYS);
    end else begin
      ways_eff = salc_pkg::WCNT_W'(ways_cfg_r);
    end
    for (int w = 0; w < salc_pkg::MAX_WAYS; w++) begin
      acc_en[w] = (w < int'(ways_eff));
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      set_r  <= acc_set;
      tag_r  <= acc_tag;
      kind_r <= salc_pkg::req_type_t'(in_ch.req_type);
      en_r   <= acc_en;
    end
  end

  // ---------------- set memory ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= wr_row;
    end
    if (mem_re) begin
      rd_row_r <= line_mem[acc_set];
    end
  end

  // ---------------- tag compare ----------------
  always_comb begin
    hit_c       = 1'b0;
    hit_way_c   = '0;
    empty_c     = 1'b0;
    empty_way_c = '0;
    for (int w = salc_pkg::MAX_WAYS - 1; w >= 0; w--) begin
      if (en_r[w] && rd_row_r.valid[w] && (rd_row_r.tag[w] == tag_r)) begin
        hit_c     = 1'b1;
        hit_way_c = salc_pkg::WAY_W'(w);
      end
      if (en_r[w] && !rd_row_r.valid[w]) begin
        empty_c     = 1'b1;
        empty_way_c = salc_pkg::WAY_W'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == salc_pkg::ST_LOOK) begin
      hit_r       <= hit_c;
      hit_way_r   <= hit_way_c;
      empty_r     <= empty_c;
      empty_way_r <= empty_way_c;
    end
    if (state_r == salc_pkg::ST_PICK) begin
      victim_r <= victim_c;
    end
  end

  // ---------------- LRU pick ----------------
  assign cand.en    = en_r;
  assign cand.stamp = rd_row_r.stamp;

  salc_victim u_victim (
    .clk    (clk),
    .cand   (cand),
    .victim (victim_c)
  );

  // ---------------- totals ----------------
  assign evict_c    = !hit_r && !empty_r;
  assign hits_mod   = (kind_r == salc_pkg::REQ_MODIFY) ? salc_pkg::sat_inc(hits_r) : hits_r;
  assign hits_nxt   = hit_r ? salc_pkg::sat_inc(hits_mod) : hits_mod;
  assign misses_nxt = hit_r ? misses_r : salc_pkg::sat_inc(misses_r);
  assign evicts_nxt = evict_c ? salc_pkg::sat_inc(evicts_r) : evicts_r;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = set_r;
    done_fire   = 1'b0;
    wr_row      = rd_row_r;
    way_sel     = hit_r ? hit_way_r : (empty_r ? empty_way_r : victim_r);
    unique case (state_r)
      salc_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        wr_row    = '0;
        if (int'(clr_cnt_r) == salc_pkg::MAX_SETS - 1) begin
          state_nxt = salc_pkg::ST_IDLE;
        end
      end
      salc_pkg::ST_IDLE: begin
        // ready is high here, so valid alone marks an accepted item
        in_ch.ready = 1'b1;
        mem_re      = in_ch.valid;
        if (in_ch.valid && (in_ch.req_type != salc_pkg::REQ_IGNORE)) begin
          state_nxt = salc_pkg::ST_LOOK;
        end
      end
      salc_pkg::ST_LOOK: state_nxt = salc_pkg::ST_PICK;
      salc_pkg::ST_PICK: state_nxt = salc_pkg::ST_DONE;
      salc_pkg::ST_DONE: begin
        // write back once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          done_fire               = 1'b1;
          mem_we                  = 1'b1;
          wr_row.valid[way_sel]   = 1'b1;
          wr_row.tag[way_sel]     = tag_r;
          wr_row.stamp[way_sel]   = clock_r;
          state_nxt               = salc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = salc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= salc_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == salc_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + salc_pkg::SET_W'(1);
      end
    end
  end

  // Totals, clock and output register load only with a result; the valid drops when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      evicts_r    <= evicts_nxt;
      clock_r     <= clock_r + salc_pkg::STAMP_W'(1);
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      o_hit_r   <= hit_r;
      o_miss_r  <= !hit_r;
      o_evict_r <= evict_c;
      o_mod_r   <= (kind_r == salc_pkg::REQ_MODIFY);
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.was_hit          = o_hit_r;
  assign out_ch.was_miss         = o_miss_r;
  assign out_ch.was_eviction     = o_evict_r;
  assign out_ch.modify_extra_hit = o_mod_r;
  assign out_ch.hit_total        = hits_r;
  assign out_ch.miss_total       = misses_r;
  assign out_ch.eviction_total   = evicts_r;

endmodule

// ===== hw/rtl/salc_victim.sv =====
// salc_victim: LRU way picker, a registered pairwise stage then a short scan.
// Depends on salc_pkg. Result is valid in the cycle after the candidates.
module salc_victim (
  input  logic                          clk,
  input  salc_pkg::cand_t               cand,
  output logic [salc_pkg::WAY_W-1:0]    victim
);

  localparam int HALF = (salc_pkg::MAX_WAYS + 1) / 2;
  localparam int PAD  = 2 * HALF;

  logic                     pad_en [PAD];
  salc_pkg::stamp_t         pad_st [PAD];
  logic                     l1_en_c  [HALF];
  salc_pkg::stamp_t         l1_st_c  [HALF];
  logic [salc_pkg::WAY_W-1:0] l1_idx_c [HALF];
  logic                     l1_en_r  [HALF];
  salc_pkg::stamp_t         l1_st_r  [HALF];
  logic [salc_pkg::WAY_W-1:0] l1_idx_r [HALF];

  // Pad to an even count; pad slots never win
  always_comb begin
    for (int w = 0; w < PAD; w++) begin
      if (w < salc_pkg::MAX_WAYS) begin
        pad_en[w] = cand.en[w];
        pad_st[w] = cand.stamp[w];
      end else begin
        pad_en[w] = 1'b0;
        pad_st[w] = '0;
      end
    end
  end

  // First level: lower way of each pair wins ties
  always_comb begin
    for (int j = 0; j < HALF; j++) begin
      if (pad_en[2*j+1] && (!pad_en[2*j] || (pad_st[2*j+1] < pad_st[2*j]))) begin
        l1_en_c[j]  = 1'b1;
        l1_st_c[j]  = pad_st[2*j+1];
        l1_idx_c[j] = salc_pkg::WAY_W'(2*j+1);
      end else begin
        l1_en_c[j]  = pad_en[2*j];
        l1_st_c[j]  = pad_st[2*j];
        l1_idx_c[j] = salc_pkg::WAY_W'(2*j);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < HALF; j++) begin
      l1_en_r[j]  <= l1_en_c[j];
      l1_st_r[j]  <= l1_st_c[j];
      l1_idx_r[j] <= l1_idx_c[j];
    end
  end

  // Scan the pair winners in way order; strict compare keeps the lowest way
  always_comb begin
    logic             best_en;
    salc_pkg::stamp_t best_st;
    best_en = l1_en_r[0];
    best_st = l1_st_r[0];
    victim  = l1_idx_r[0];
    for (int j = 1; j < HALF; j++) begin
      if (l1_en_r[j] && (!best_en || (l1_st_r[j] < best_st))) begin
        best_en = 1'b1;
        best_st = l1_st_r[j];
        victim  = l1_idx_r[j];
      end
    end
  end

endmodule

// ===== hw/rtl/salc_checker.sv =====
// salc_checker: port-level assertions for set_assoc_lru_cache_sim, and the
// bind that attaches them. Depends on salc_pkg and the top level's ports.
module salc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_req_type,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_was_hit,
  input logic               out_was_miss,
  input logic               out_was_eviction,
  input logic               out_modify_extra_hit,
  input salc_pkg::total_t   out_hit_total,
  input salc_pkg::total_t   out_miss_total,
  input salc_pkg::total_t   out_eviction_total
);

  // A pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_was_hit) && $stable(out_was_miss)
      && $stable(out_was_eviction) && $stable(out_modify_extra_hit)
      && $stable(out_hit_total) && $stable(out_miss_total)
      && $stable(out_eviction_total))
    else $error("stalled result changed");

  // One access in flight: a real access blocks the input next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type != salc_pkg::REQ_IGNORE) |=> !in_ready)
    else $error("input taken while an access is in flight");

  // A new result only appears while an access was being finished
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an access in flight");

endmodule

bind set_assoc_lru_cache_sim salc_checker u_salc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .in_req_type          (in_ch.req_type),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_was_hit          (out_ch.was_hit),
  .out_was_miss         (out_ch.was_miss),
  .out_was_eviction     (out_ch.was_eviction),
  .out_modify_extra_hit (out_ch.modify_extra_hit),
  .out_hit_total        (out_ch.hit_total),
  .out_miss_total       (out_ch.miss_total),
  .out_eviction_total   (out_ch.eviction_total)
);
